// ===== sv/gdrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package gdrc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int COORD_W   = 13;
  localparam int CELL_W    = 5;
  localparam int DIST_W    = 16;

  // squares and root of the ray length
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int RAD_W  = 44;
  localparam int ROOT_W = RAD_W / 2;
  // side lengths, walked distance
  localparam int LEN_W  = 24;
  // shared divider
  localparam int NUM_W  = COORD_W + LEN_W + FRAC_BITS;
  localparam int DEN_W  = ROOT_W;

  localparam logic [1:0] FUNC_CAST   = 2'd0;
  localparam logic [1:0] FUNC_TOGGLE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  localparam int          REG_ADDR_W   = 3;
  localparam logic        REG_MAX_DIST = 1'b0;
  localparam logic [15:0] MAXD_RESET   = 16'd25600;

  typedef struct packed {
    logic [1:0]         func;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] target_x;
    logic [COORD_W-1:0] target_y;
    logic [CELL_W-1:0]  cell_col;
    logic [CELL_W-1:0]  cell_row;
  } in_req_t;

  typedef struct packed {
    logic               hit;
    logic [CELL_W-1:0]  hit_col;
    logic [CELL_W-1:0]  hit_row;
    logic [DIST_W-1:0]  hit_distance;
    logic [COORD_W-1:0] hit_x;
    logic [COORD_W-1:0] hit_y;
  } out_rsp_t;

endpackage
`default_nettype wire

// ===== sv/gdrc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module gdrc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== sv/gdrc_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// digit-by-digit integer root, one result bit per cycle
module gdrc_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [gdrc_pkg::RAD_W-1:0]  radicand,
  output logic                             done,
  output logic      [gdrc_pkg::ROOT_W-1:0] root
);

  localparam int REM_W = gdrc_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(gdrc_pkg::ROOT_W + 1);

  logic [gdrc_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]           rem;
  logic [CNT_W-1:0]           cnt;
  logic [REM_W+1:0]           rem_sh;
  logic [REM_W+1:0]           trial;
  logic                       take;

  assign rem_sh = {rem, rad[gdrc_pkg::RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(gdrc_pkg::ROOT_W);
      end else if (cnt != '0) begin
        rad  <= rad << 2;
        rem  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root <= {root[gdrc_pkg::ROOT_W-2:0], take};
        cnt  <= cnt - 1'b1;
        done <= cnt == CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/gdrc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
module gdrc_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [gdrc_pkg::NUM_W-1:0] num,
  input  wire logic [gdrc_pkg::DEN_W-1:0] den,
  output logic                            done,
  output logic      [gdrc_pkg::NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(gdrc_pkg::NUM_W + 1);

  logic [gdrc_pkg::DEN_W-1:0] den_q;
  logic [gdrc_pkg::DEN_W-1:0] rem;
  logic [CNT_W-1:0]           cnt;
  logic [gdrc_pkg::DEN_W:0]   rem_sh;
  logic                       take;

  assign rem_sh = {rem, quot[gdrc_pkg::NUM_W-1]};
  assign take   = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quot  <= num;
        den_q <= den;
        rem   <= '0;
        cnt   <= CNT_W'(gdrc_pkg::NUM_W);
      end else if (cnt != '0) begin
        rem  <= take ? gdrc_pkg::DEN_W'(rem_sh - {1'b0, den_q})
                     : gdrc_pkg::DEN_W'(rem_sh);
        quot <= {quot[gdrc_pkg::NUM_W-2:0], take};
        cnt  <= cnt - 1'b1;
        done <= cnt == CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/grid_dda_ray_cast_top.sv =====
// Grid ray caster: DDA walk over a GRID_DIM x GRID_DIM one-bit occupancy grid.
// Request channel in_valid/in_stall/in_data: func selects cast (0), toggle a cell (1),
// clear the grid (2); code 3 does nothing. Every request gives exactly one response
// on out_valid/out_stall/out_data; toggle, clear and misses respond with all zeros.
// max_distance is written over the APB port at byte address 0; pready is always high.
// One request is worked at a time. A cast squares the deltas, takes the root, divides
// for the unit step of each axis (skipped for a zero-delta axis), then walks the cells;
// a hit adds two divisions for the intersection point. Each cell of the walk takes one
// synchronous read of the grid memory and the check of its data. Root and divisions
// run one bit per cycle in shared units. After reset a clearing pass writes every grid
// entry with in_stall held high; configuration writes are taken throughout.
// A finished response sits in the output register until taken; the next request may
// be accepted meanwhile, and its own response waits for the register to free up.
`timescale 1ns / 1ps
`default_nettype none
module grid_dda_ray_cast_top #(
  parameter int GRID_DIM = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire gdrc_pkg::in_req_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output gdrc_pkg::out_rsp_t                       out_data,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [gdrc_pkg::REG_ADDR_W-1:0]     paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int FB    = gdrc_pkg::FRAC_BITS;
  localparam int CW    = gdrc_pkg::COORD_W;
  localparam int LW    = gdrc_pkg::LEN_W;
  localparam int POS_W = 11;
  localparam int PRODW = CW + LW;
  localparam logic signed [POS_W-1:0] GRID_LIM = POS_W'(GRID_DIM);
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_TGL_WR, S_SQ, S_ROOT_GO, S_ROOT_WAIT,
    S_DIV_GO, S_DIV_WAIT, S_INIT, S_WALK, S_CHECK, S_OFF_MUL, S_PLACE, S_DONE
  } state_t;

  typedef enum logic [1:0] {DS_STX, DS_STY, DS_OFX, DS_OFY} div_sel_t;

  state_t                     state;
  div_sel_t                   div_sel;
  gdrc_pkg::in_req_t          req;
  gdrc_pkg::out_rsp_t         rsp;
  logic [AW-1:0]              clr_cnt;
  logic                       clr_item;
  logic [15:0]                maxd;
  logic                       negx, negy, infx, infy;
  logic [CW-1:0]              adx, ady;
  logic [2*CW-1:0]            sqx, sqy;
  logic [gdrc_pkg::ROOT_W-1:0] len;
  logic [gdrc_pkg::ROOT_W-1:0] stx, sty;
  logic [LW-1:0]              lx, ly, walked, offx, offy;
  logic signed [POS_W-1:0]    mx, my;
  logic                       chk_in;
  logic [PRODW-1:0]           prodx, prody;

  // grid memory port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [0:0]    ram_wdata, ram_rdata;

  // shared units
  logic                         sqrt_start, sqrt_done;
  logic [gdrc_pkg::RAD_W-1:0]   radicand;
  logic [gdrc_pkg::ROOT_W-1:0]  root;
  logic [gdrc_pkg::SQ_W-1:0]    sqsum;
  logic                         div_start, div_done, div_skip;
  logic [gdrc_pkg::NUM_W-1:0]   div_num, quot;
  logic [gdrc_pkg::DEN_W-1:0]   div_den;

  // walk step
  logic                    takex, inside_n;
  logic signed [POS_W-1:0] mx_n, my_n;
  logic [AW-1:0]           walk_addr, tgl_addr;
  logic                    tgl_ok, cfg_wr;
  logic [FB:0]             fwx, fwy;
  logic [FB+gdrc_pkg::ROOT_W:0] initx, inity;

  function automatic logic [CW-1:0] place(input logic [CW-1:0] s, input logic neg,
                                          input logic [LW-1:0] off);
    logic [LW:0] sum;
    sum = (LW + 1)'(s) + (LW + 1)'(off);
    if (neg) begin
      place = (off >= LW'(s)) ? '0 : CW'(LW'(s) - off);
    end else begin
      place = (sum > (LW + 1)'({CW{1'b1}})) ? {CW{1'b1}} : CW'(sum);
    end
  endfunction

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[gdrc_pkg::REG_ADDR_W-1:2] == gdrc_pkg::REG_MAX_DIST);
  assign prdata = (paddr[gdrc_pkg::REG_ADDR_W-1:2] == gdrc_pkg::REG_MAX_DIST)
                  ? {16'b0, maxd} : '0;

  assign in_stall = state != S_IDLE;

  // ---------------------------------------------------------------- datapath
  assign sqsum    = gdrc_pkg::SQ_W'(sqx) + gdrc_pkg::SQ_W'(sqy);
  assign radicand = gdrc_pkg::RAD_W'({sqsum, {(2 * FB){1'b0}}});

  assign div_skip = (div_sel == DS_STX && adx == '0) || (div_sel == DS_STY && ady == '0);
  assign div_start  = (state == S_DIV_GO) && !div_skip;
  assign sqrt_start = state == S_ROOT_GO;

  always_comb begin
    unique case (div_sel)
      DS_STX: begin
        div_num = gdrc_pkg::NUM_W'(len);
        div_den = gdrc_pkg::DEN_W'(adx);
      end
      DS_STY: begin
        div_num = gdrc_pkg::NUM_W'(len);
        div_den = gdrc_pkg::DEN_W'(ady);
      end
      DS_OFX: begin
        div_num = gdrc_pkg::NUM_W'({prodx, {FB{1'b0}}});
        div_den = len;
      end
      default: begin
        div_num = gdrc_pkg::NUM_W'({prody, {FB{1'b0}}});
        div_den = len;
      end
    endcase
  end

  // first side lengths: fraction to the first boundary times the unit step
  assign fwx   = negx ? (FB + 1)'(req.start_x[FB-1:0]) : ONE - (FB + 1)'(req.start_x[FB-1:0]);
  assign fwy   = negy ? (FB + 1)'(req.start_y[FB-1:0]) : ONE - (FB + 1)'(req.start_y[FB-1:0]);
  assign initx = fwx * stx;
  assign inity = fwy * sty;

  // x advances only when strictly nearer; a zero-delta axis never advances
  assign takex    = !infx && (infy || lx < ly);
  assign mx_n     = takex ? (negx ? mx - POS_W'(1) : mx + POS_W'(1)) : mx;
  assign my_n     = takex ? my : (negy ? my - POS_W'(1) : my + POS_W'(1));
  assign inside_n = mx_n >= 0 && mx_n < GRID_LIM && my_n >= 0 && my_n < GRID_LIM;
  assign walk_addr = AW'(my_n) * AW'(GRID_DIM) + AW'(mx_n);

  assign tgl_ok   = (int'(req.cell_col) < GRID_DIM) && (int'(req.cell_row) < GRID_DIM);
  assign tgl_addr = AW'(req.cell_row) * AW'(GRID_DIM) + AW'(req.cell_col);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_addr  = tgl_addr;
    unique case (state)
      S_CLEAR:  begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt;
      end
      S_TGL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ~ram_rdata;
      end
      S_WALK:   ram_addr = walk_addr;
      default:  ram_addr = tgl_addr;
    endcase
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      clr_item  <= 1'b0;
      out_valid <= 1'b0;
      maxd      <= gdrc_pkg::MAXD_RESET;
      div_sel   <= DS_STX;
    end else begin
      // S_DONE reloads the output register itself
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        maxd <= pwdata[15:0];
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            clr_cnt <= '0;
            state   <= clr_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          rsp  <= '0;
          negx <= req.target_x < req.start_x;
          negy <= req.target_y < req.start_y;
          adx  <= (req.target_x < req.start_x) ? req.start_x - req.target_x
                                               : req.target_x - req.start_x;
          ady  <= (req.target_y < req.start_y) ? req.start_y - req.target_y
                                               : req.target_y - req.start_y;
          infx <= req.target_x == req.start_x;
          infy <= req.target_y == req.start_y;
          unique case (req.func)
            gdrc_pkg::FUNC_CAST: begin
              state <= (req.target_x == req.start_x && req.target_y == req.start_y)
                       ? S_DONE : S_SQ;
            end
            gdrc_pkg::FUNC_TOGGLE: state <= tgl_ok ? S_TGL_WR : S_DONE;
            gdrc_pkg::FUNC_CLEAR: begin
              clr_item <= 1'b1;
              state    <= S_CLEAR;
            end
            default: state <= S_DONE;
          endcase
        end
        S_TGL_WR: state <= S_DONE;
        S_SQ: begin
          sqx   <= adx * adx;
          sqy   <= ady * ady;
          state <= S_ROOT_GO;
        end
        S_ROOT_GO: state <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (sqrt_done) begin
            len     <= root;
            div_sel <= DS_STX;
            state   <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          if (div_skip) begin
            if (div_sel == DS_STX) begin
              div_sel <= DS_STY;
            end else begin
              state <= S_INIT;
            end
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            unique case (div_sel)
              DS_STX: begin
                stx     <= gdrc_pkg::ROOT_W'(quot);
                div_sel <= DS_STY;
                state   <= S_DIV_GO;
              end
              DS_STY: begin
                sty   <= gdrc_pkg::ROOT_W'(quot);
                state <= S_INIT;
              end
              DS_OFX: begin
                offx    <= LW'(quot);
                div_sel <= DS_OFY;
                state   <= S_DIV_GO;
              end
              default: begin
                offy  <= LW'(quot);
                state <= S_PLACE;
              end
            endcase
          end
        end
        S_INIT: begin
          lx     <= LW'(initx >> FB);
          ly     <= LW'(inity >> FB);
          mx     <= POS_W'(req.start_x[CW-1:FB]);
          my     <= POS_W'(req.start_y[CW-1:FB]);
          walked <= '0;
          state  <= S_WALK;
        end
        S_WALK: begin
          if (walked >= LW'(maxd)) begin
            state <= S_DONE;
          end else begin
            mx     <= mx_n;
            my     <= my_n;
            chk_in <= inside_n;
            if (takex) begin
              walked <= lx;
              lx     <= lx + LW'(stx);
            end else begin
              walked <= ly;
              ly     <= ly + LW'(sty);
            end
            state <= S_CHECK;
          end
        end
        S_CHECK: state <= (chk_in && ram_rdata[0]) ? S_OFF_MUL : S_WALK;
        S_OFF_MUL: begin
          prodx   <= adx * walked;
          prody   <= ady * walked;
          div_sel <= DS_OFX;
          state   <= S_DIV_GO;
        end
        S_PLACE: begin
          rsp.hit          <= 1'b1;
          rsp.hit_col      <= mx[gdrc_pkg::CELL_W-1:0];
          rsp.hit_row      <= my[gdrc_pkg::CELL_W-1:0];
          rsp.hit_distance <= (walked > LW'(16'hFFFF)) ? 16'hFFFF : walked[15:0];
          rsp.hit_x        <= place(req.start_x, negx, offx);
          rsp.hit_y        <= place(req.start_y, negy, offy);
          state            <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data  <= rsp;
            out_valid <= 1'b1;
            clr_item  <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  gdrc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  gdrc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  gdrc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // ---------------------------------------------------------------- checks
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.hit) |-> (out_data.hit_distance == '0 && out_data.hit_x == '0 &&
      out_data.hit_y == '0 && out_data.hit_col == '0 && out_data.hit_row == '0))
    else $error("miss response carries non-zero fields");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in work");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (in_stall && ram_we))
    else $error("clearing pass not holding off requests");

  a_hit_ends_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && chk_in && ram_rdata[0]) |=> (state == S_OFF_MUL))
    else $error("occupied cell did not end the walk");

endmodule
`default_nettype wire
